// ===== hw/rtl/serial_frame_deframer_defines.svh =====
// assertion macros for the serial frame deframer
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_DEFINES_SVH

// property that must hold on every clock out of reset
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
// shared types and constants of the serial frame deframer
// no dependencies
`default_nettype none

package sfd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] RST_START_FLAG = 8'd126;
    localparam logic [7:0] RST_ALT_FLAG   = 8'd125;
    localparam logic [7:0] RST_IDLE_LIMIT = 8'd5;
    localparam logic [7:0] IDLE_SAT       = 8'd255;

    localparam logic [1:0] CFG_START_FLAG = 2'd0;
    localparam logic [1:0] CFG_ALT_FLAG   = 2'd1;
    localparam logic [1:0] CFG_IDLE_LIMIT = 2'd2;

    localparam logic [2:0] SEC_FLAG    = 3'd0;
    localparam logic [2:0] SEC_SOURCE  = 3'd1;
    localparam logic [2:0] SEC_REMOTE  = 3'd2;
    localparam logic [2:0] SEC_LENGTH  = 3'd3;
    localparam logic [2:0] SEC_PAYLOAD = 3'd4;
    localparam logic [2:0] SEC_CRC     = 3'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] CRC_BYTES = 2'd2;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_SRC  = 3'd1,
        PH_DST  = 3'd2,
        PH_LEN  = 3'd3,
        PH_PAY  = 3'd4,
        PH_CRC  = 3'd5
    } t_phase;

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  section;
        logic        frame_last;
        logic        frame_abort;
        logic [7:0]  src_id;
        logic [7:0]  dst_id;
        logic [15:0] payload_len;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/serial_frame_deframer.sv =====
// serial frame deframer top level: front end, result queue, output stage
// depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_op, i_rx_byte
// result    out        o_out_valid / i_out_stall  o_out_byte .. o_payload_len
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per cycle unless stalled; the frame state updates in its transfer cycle
// a result passes through the result queue into the output register
// the 4-entry result queue absorbs output stalls; input stalls only when it is full
// config writes are taken every cycle; reset is synchronous, active low, no clearing pass
`default_nettype none

module serial_frame_deframer
    import sfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_section,
    output logic             o_frame_last,
    output logic             o_frame_abort,
    output logic [7:0]       o_src_id,
    output logic [7:0]       o_dst_id,
    output logic [15:0]      o_payload_len,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    t_cfg_wr cfg;
    logic    accept, res_valid, q_empty, q_full, q_pop;
    t_result res, q_head, out;

    assign o_cfg_ready = 1'b1;
    assign cfg.we      = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    sfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (out)
    );

    assign o_out_byte    = out.out_byte;
    assign o_section     = out.section;
    assign o_frame_last  = out.frame_last;
    assign o_frame_abort = out.frame_abort;
    assign o_src_id      = out.src_id;
    assign o_dst_id      = out.dst_id;
    assign o_payload_len = out.payload_len;

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_front.sv =====
// front end: config registers, frame state machine, result generation
// depends on sfd_pkg
`default_nettype none

module sfd_front
    import sfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_accept,
    input  wire logic    i_op,
    input  wire logic [7:0] i_rx_byte,
    output logic         o_res_valid,
    output t_result      o_res
);

    logic [7:0]  r_start_flag, r_alt_flag, r_idle_limit;
    t_phase      r_phase, n_phase;
    logic        r_len_low, n_len_low;
    logic [7:0]  r_src, n_src;
    logic [7:0]  r_dst, n_dst;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pay_cnt, n_pay_cnt;
    logic [1:0]  r_crc_cnt, n_crc_cnt;
    logic [7:0]  r_idle, n_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_flag <= RST_START_FLAG;
            r_alt_flag   <= RST_ALT_FLAG;
            r_idle_limit <= RST_IDLE_LIMIT;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_START_FLAG: r_start_flag <= i_cfg.data;
                CFG_ALT_FLAG:   r_alt_flag   <= i_cfg.data;
                CFG_IDLE_LIMIT: r_idle_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_len_low <= 1'b0;
            r_src     <= 8'd0;
            r_dst     <= 8'd1;
            r_len     <= 16'd0;
            r_pay_cnt <= 16'd0;
            r_crc_cnt <= 2'd0;
            r_idle    <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_len_low <= n_len_low;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_len     <= n_len;
            r_pay_cnt <= n_pay_cnt;
            r_crc_cnt <= n_crc_cnt;
            r_idle    <= n_idle;
        end
    end

    logic [15:0] pay_next;
    logic [1:0]  crc_next;
    logic [7:0]  res_byte;
    logic [2:0]  res_sec;
    logic        res_last, res_abort;

    assign pay_next = r_pay_cnt + 16'd1;
    assign crc_next = r_crc_cnt + 2'd1;

    always_comb begin
        n_phase     = r_phase;
        n_len_low   = r_len_low;
        n_src       = r_src;
        n_dst       = r_dst;
        n_len       = r_len;
        n_pay_cnt   = r_pay_cnt;
        n_crc_cnt   = r_crc_cnt;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        res_byte    = i_rx_byte;
        res_sec     = SEC_FLAG;
        res_last    = 1'b0;
        res_abort   = 1'b0;
        if (i_accept) begin
            if (i_op == OP_TICK) begin
                n_idle = (r_idle == IDLE_SAT) ? r_idle : r_idle + 8'd1;
                if (n_idle > r_idle_limit && r_phase != PH_WAIT) begin
                    n_phase     = PH_WAIT;
                    n_len_low   = 1'b0;
                    o_res_valid = 1'b1;
                    res_byte    = 8'd0;
                    res_abort   = 1'b1;
                end
            end else begin
                n_idle = 8'd0;
                case (r_phase)
                    PH_WAIT: begin
                        if (i_rx_byte == r_start_flag || i_rx_byte == r_alt_flag) begin
                            n_phase     = PH_SRC;
                            n_len_low   = 1'b0;
                            o_res_valid = 1'b1;
                        end
                    end
                    PH_SRC: begin
                        n_src       = i_rx_byte;
                        n_phase     = PH_DST;
                        o_res_valid = 1'b1;
                        res_sec     = SEC_SOURCE;
                    end
                    PH_DST: begin
                        n_dst       = i_rx_byte;
                        n_phase     = PH_LEN;
                        o_res_valid = 1'b1;
                        res_sec     = SEC_REMOTE;
                    end
                    PH_LEN: begin
                        // little-endian: low byte first
                        if (!r_len_low) begin
                            n_len     = {8'd0, i_rx_byte};
                            n_len_low = 1'b1;
                        end else begin
                            n_len     = {i_rx_byte, r_len[7:0]};
                            n_len_low = 1'b0;
                            n_pay_cnt = 16'd0;
                            n_phase   = PH_PAY;
                        end
                        o_res_valid = 1'b1;
                        res_sec     = SEC_LENGTH;
                    end
                    PH_PAY: begin
                        // zero length still consumes one byte
                        n_pay_cnt = pay_next;
                        if (pay_next >= r_len) begin
                            n_crc_cnt = 2'd0;
                            n_phase   = PH_CRC;
                        end
                        o_res_valid = 1'b1;
                        res_sec     = SEC_PAYLOAD;
                    end
                    PH_CRC: begin
                        n_crc_cnt   = crc_next;
                        o_res_valid = 1'b1;
                        res_sec     = SEC_CRC;
                        if (crc_next >= CRC_BYTES) begin
                            n_phase  = PH_WAIT;
                            res_last = 1'b1;
                        end
                    end
                    default: begin
                        n_phase   = PH_WAIT;
                        n_len_low = 1'b0;
                    end
                endcase
            end
        end
        o_res.out_byte    = res_byte;
        o_res.section     = res_sec;
        o_res.frame_last  = res_last;
        o_res.frame_abort = res_abort;
        o_res.src_id      = n_src;
        o_res.dst_id      = n_dst;
        o_res.payload_len = n_len;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_queue.sv =====
// short result queue between the front end and the output stage
// depends on sfd_pkg and serial_frame_deframer_defines.svh
`default_nettype none
`include "serial_frame_deframer_defines.svh"

module sfd_queue
    import sfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output t_result      o_head,
    output logic         o_empty,
    output logic         o_full
);

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QAW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QAW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: ;
            endcase
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCW'(QDEPTH));

    `SFD_ASSERT_ALWAYS(a_count_bound, r_count <= QCW'(QDEPTH), "queue count over depth")
    `SFD_ASSERT_IMP(a_no_pop_empty, i_pop, r_count != '0, "pop from empty queue")
    `SFD_ASSERT_IMP(a_no_push_full, i_push, r_count != QCW'(QDEPTH), "push into full queue")
    `SFD_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + QCW'(1),
        "queue count did not grow on push")

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_back.sv =====
// output stage: registered result, refilled from the queue when empty or not stalled
// depends on sfd_pkg
`default_nettype none

module sfd_back
    import sfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_empty,
    input  wire t_result i_q_head,
    output logic         o_q_pop,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    output t_result      o_out
);

    logic    r_valid;
    t_result r_out;

    // refill when the register is empty or its transfer completes now
    assign o_q_pop = !i_q_empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= i_q_head;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
